[design/cal_clk_pkg.sv]
// Shared types, constants and calendar functions for the calendar clock core.
// Used by calendar_clock_tick_and_set_core; depends on nothing else.
package cal_clk_pkg;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [5:0] SEC_MAX      = 6'd59;
    localparam logic [5:0] MIN_MAX      = 6'd59;
    localparam logic [4:0] HOUR_MAX     = 5'd23;
    localparam logic [6:0] YEAR_MAX     = 7'd99;
    localparam logic [3:0] MONTH_MAX    = 4'd12;
    localparam logic [3:0] WEEKDAY_WRAP = 4'd8;
    localparam logic [2:0] WEEKDAY_RST  = 3'd6;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] new_year;
        logic [3:0] new_month;
        logic [4:0] new_day;
        logic [4:0] new_hour;
        logic [5:0] new_minute;
        logic [5:0] new_second;
    } cal_in_t;

    typedef struct packed {
        logic [6:0] cur_year;
        logic [3:0] cur_month;
        logic [4:0] cur_day;
        logic [4:0] cur_hour;
        logic [5:0] cur_minute;
        logic [5:0] cur_second;
        logic [2:0] cur_weekday;
        logic       day_rolled;
        logic       set_refused;
    } cal_out_t;

    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic [6:0] year);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] month_offset(input logic [3:0] month);
        logic [2:0] off;
        unique case (month)
            4'd1:    off = 3'd6;
            4'd2:    off = 3'd2;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    // Sum mod 7 by folding 3-bit digits (8 mod 7 == 1); Sunday stored as 7.
    function automatic logic [2:0] weekday_of(input logic [6:0] y,
                                              input logic [3:0] m,
                                              input logic [4:0] d);
        logic [7:0] sum;
        logic [4:0] fold1;
        logic [3:0] fold2;
        logic [2:0] wd;
        sum = {1'b0, y} + {3'b0, y[6:2]} + {5'b0, month_offset(m)} + {3'b0, d}
            + 8'd7 - {7'b0, (m < 4'd3) && (y[1:0] == 2'd0)};
        fold1 = {3'b0, sum[7:6]} + {2'b0, sum[5:3]} + {2'b0, sum[2:0]};
        fold2 = {2'b0, fold1[4:3]} + {1'b0, fold1[2:0]};
        unique case (fold2)
            4'd0, 4'd7: wd = 3'd7;
            4'd8:       wd = 3'd1;
            4'd9:       wd = 3'd2;
            default:    wd = fold2[2:0];
        endcase
        return wd;
    endfunction

endpackage

[design/calendar_clock_tick_and_set_core.sv]
// Calendar clock core: tick, set and read commands on a two-digit-year calendar.
// A word accepted on s_ is held in the input register, then loaded into the result
// register when the output stage advances, and offered on m_. Throughput: one word per
// cycle unless m_ready stalls, set by the tick/set logic feeding the time registers.
// Reset (aresetn low, synchronous): 2000-01-01 00:00:00 Saturday, both stages empty.
// Depends on cal_clk_pkg.
module calendar_clock_tick_and_set_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cal_clk_pkg::cal_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cal_clk_pkg::cal_out_t m_data
);

    logic                  in_valid_reg;
    cal_clk_pkg::cal_in_t  in_data_reg;
    logic                  out_valid_reg;
    cal_clk_pkg::cal_out_t out_data_reg;

    logic [5:0] sec_reg,   sec_next;
    logic [5:0] min_reg,   min_next;
    logic [4:0] hour_reg,  hour_next;
    logic [4:0] day_reg,   day_next;
    logic [3:0] month_reg, month_next;
    logic [6:0] year_reg,  year_next;
    logic [2:0] wd_reg,    wd_next;
    logic       rolled, refused;

    logic       advance;
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [5:0] day_inc;
    logic [4:0] month_inc;
    logic [7:0] year_inc;
    logic [3:0] wd_inc;
    logic [4:0] cur_len;
    logic       set_ok;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign sec_inc   = {1'b0, sec_reg} + 7'd1;
    assign min_inc   = {1'b0, min_reg} + 7'd1;
    assign hour_inc  = {1'b0, hour_reg} + 6'd1;
    assign day_inc   = {1'b0, day_reg} + 6'd1;
    assign month_inc = {1'b0, month_reg} + 5'd1;
    assign year_inc  = {1'b0, year_reg} + 8'd1;
    assign wd_inc    = {1'b0, wd_reg} + 4'd1;
    assign cur_len   = cal_clk_pkg::month_length(month_reg, year_reg);

    assign set_ok = (in_data_reg.new_year <= cal_clk_pkg::YEAR_MAX)
        && (in_data_reg.new_month != 4'd0)
        && (in_data_reg.new_month <= cal_clk_pkg::MONTH_MAX)
        && (in_data_reg.new_day != 5'd0)
        && (in_data_reg.new_day <= cal_clk_pkg::month_length(in_data_reg.new_month,
                                                             in_data_reg.new_year))
        && (in_data_reg.new_hour <= cal_clk_pkg::HOUR_MAX)
        && (in_data_reg.new_minute <= cal_clk_pkg::MIN_MAX)
        && (in_data_reg.new_second <= cal_clk_pkg::SEC_MAX);

    always_comb begin
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        wd_next    = wd_reg;
        rolled     = 1'b0;
        refused    = 1'b0;
        unique case (in_data_reg.cmd)
            cal_clk_pkg::CMD_TICK: begin
                sec_next = sec_inc[5:0];
                if (sec_inc > {1'b0, cal_clk_pkg::SEC_MAX}) begin
                    sec_next = 6'd0;
                    min_next = min_inc[5:0];
                    if (min_inc > {1'b0, cal_clk_pkg::MIN_MAX}) begin
                        min_next  = 6'd0;
                        hour_next = hour_inc[4:0];
                        if (hour_inc > {1'b0, cal_clk_pkg::HOUR_MAX}) begin
                            hour_next = 5'd0;
                            rolled    = 1'b1;
                            wd_next   = (wd_inc >= cal_clk_pkg::WEEKDAY_WRAP) ?
                                        3'd1 : wd_inc[2:0];
                            day_next  = day_inc[4:0];
                            if (day_inc > {1'b0, cur_len}) begin
                                day_next   = 5'd1;
                                month_next = month_inc[3:0];
                                if (month_inc > {1'b0, cal_clk_pkg::MONTH_MAX}) begin
                                    month_next = 4'd1;
                                    year_next  = (year_inc > {1'b0, cal_clk_pkg::YEAR_MAX}) ?
                                                 7'd0 : year_inc[6:0];
                                end
                            end
                        end
                    end
                end
            end
            cal_clk_pkg::CMD_SET: begin
                if (set_ok) begin
                    year_next  = in_data_reg.new_year;
                    month_next = in_data_reg.new_month;
                    day_next   = in_data_reg.new_day;
                    hour_next  = in_data_reg.new_hour;
                    min_next   = in_data_reg.new_minute;
                    sec_next   = in_data_reg.new_second;
                    wd_next    = cal_clk_pkg::weekday_of(in_data_reg.new_year,
                                                         in_data_reg.new_month,
                                                         in_data_reg.new_day);
                end else begin
                    refused = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sec_reg       <= 6'd0;
            min_reg       <= 6'd0;
            hour_reg      <= 5'd0;
            day_reg       <= 5'd1;
            month_reg     <= 4'd1;
            year_reg      <= 7'd0;
            wd_reg        <= cal_clk_pkg::WEEKDAY_RST;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_valid_reg && advance) begin
                sec_reg   <= sec_next;
                min_reg   <= min_next;
                hour_reg  <= hour_next;
                day_reg   <= day_next;
                month_reg <= month_next;
                year_reg  <= year_next;
                wd_reg    <= wd_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (in_valid_reg && advance) begin
            out_data_reg.cur_year    <= year_next;
            out_data_reg.cur_month   <= month_next;
            out_data_reg.cur_day     <= day_next;
            out_data_reg.cur_hour    <= hour_next;
            out_data_reg.cur_minute  <= min_next;
            out_data_reg.cur_second  <= sec_next;
            out_data_reg.cur_weekday <= wd_next;
            out_data_reg.day_rolled  <= rolled;
            out_data_reg.set_refused <= refused;
        end
    end

    a_time_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (sec_reg <= cal_clk_pkg::SEC_MAX) && (min_reg <= cal_clk_pkg::MIN_MAX)
        && (hour_reg <= cal_clk_pkg::HOUR_MAX) && (year_reg <= cal_clk_pkg::YEAR_MAX)
        && (month_reg != 4'd0) && (month_reg <= cal_clk_pkg::MONTH_MAX)
        && (day_reg != 5'd0) && (day_reg <= cur_len) && (wd_reg != 3'd0))
        else $error("calendar state out of range");

    a_roll_at_midnight: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.day_rolled |->
        (out_data_reg.cur_hour == 5'd0) && (out_data_reg.cur_minute == 6'd0)
        && (out_data_reg.cur_second == 6'd0))
        else $error("day rollover without midnight time");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_data_reg.day_rolled && out_data_reg.set_refused))
        else $error("rollover and refusal flagged together");

    a_stage_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg)
        && $stable(sec_reg) && $stable(day_reg))
        else $error("stalled word lost or state moved");

endmodule
